@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a implies b on the same edge.
`define ASSERT_IMPLIES(label, clk, rstn, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) else $error(msg);

// Check that a implies b on the next edge.
`define ASSERT_NEXT(label, clk, rstn, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) else $error(msg);

`endif

@@ hw/rtl/bst_pkg.sv @@
// ----------------------------------------------------------------------------
// bst_pkg
// Shared types, token codes and keyword table for the source tokenizer.
// ----------------------------------------------------------------------------
package bst_pkg;

    localparam int KwLen  = 9;
    localparam int LenW   = 16;
    localparam int PosW   = 32;
    localparam logic [LenW-1:0] LenMax = '1;

    typedef enum logic [3:0] {
        M_IDLE    = 4'd0,
        M_IDENT   = 4'd1,
        M_NUMBER  = 4'd2,
        M_STRING  = 4'd3,
        M_COMMENT = 4'd4,
        M_ASSIGN  = 4'd5,
        M_LESS    = 4'd6,
        M_SIGN    = 4'd7
    } mode_t;

    localparam logic [5:0] T_EOF    = 6'd0;
    localparam logic [5:0] T_ASSIGN = 6'd28;
    localparam logic [5:0] T_EQUAL  = 6'd29;
    localparam logic [5:0] T_PLUS   = 6'd30;
    localparam logic [5:0] T_MINUS  = 6'd31;
    localparam logic [5:0] T_LESS   = 6'd34;
    localparam logic [5:0] T_NOTEQ  = 6'd36;
    localparam logic [5:0] T_IDENT  = 6'd39;
    localparam logic [5:0] T_FLOAT  = 6'd40;
    localparam logic [5:0] T_INT    = 6'd41;
    localparam logic [5:0] T_STRING = 6'd42;
    localparam logic [5:0] T_UNTERM = 6'd43;
    localparam logic [5:0] T_BAD    = 6'd44;

    typedef struct packed {
        logic [5:0]      ttype;
        logic [PosW-1:0] pos;
        logic [LenW-1:0] len;
    } tok_t;

    // Up to two tokens per request, produced by the front end.
    typedef struct packed {
        logic [1:0] cnt;
        tok_t       t0;
        tok_t       t1;
    } entry_t;

    typedef logic [KwLen*8-1:0] window_t;

    function automatic logic [5:0] single_symbol(input logic [7:0] b);
        logic [5:0] r;
        r = 6'd0;
        case (b)
            8'h28: r = 6'd24;
            8'h29: r = 6'd25;
            8'h5B: r = 6'd26;
            8'h5D: r = 6'd27;
            8'h3D: r = 6'd28;
            8'h2B: r = 6'd30;
            8'h2D: r = 6'd31;
            8'h2A: r = 6'd32;
            8'h2F: r = 6'd33;
            8'h3C: r = 6'd34;
            8'h3E: r = 6'd35;
            8'h2C: r = 6'd37;
            8'h2E: r = 6'd38;
            default: r = 6'd0;
        endcase
        return r;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return b == 8'h20 || b == 8'h09 || b == 8'h0A;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic is_delim(input logic [7:0] b);
        return is_space(b) || b == 8'h23 || b == 8'h22 || single_symbol(b) != 6'd0;
    endfunction

    // Pack a short text into window form, byte 0 in the low bits.
    function automatic window_t kw_pack(input string s);
        window_t w;
        w = '0;
        for (int i = 0; i < s.len() && i < KwLen; i++) begin
            w[i*8 +: 8] = s[i];
        end
        return w;
    endfunction

    // Keyword lookup: full compare of window and length.
    function automatic logic [5:0] keyword_code(input window_t w, input logic [LenW-1:0] len);
        logic [5:0] r;
        r = 6'd0;
        if      (len == 16'd3 && w == kw_pack("and"))       r = 6'd1;
        else if (len == 16'd2 && w == kw_pack("as"))        r = 6'd2;
        else if (len == 16'd4 && w == kw_pack("case"))      r = 6'd3;
        else if (len == 16'd2 && w == kw_pack("do"))        r = 6'd4;
        else if (len == 16'd4 && w == kw_pack("else"))      r = 6'd5;
        else if (len == 16'd3 && w == kw_pack("end"))       r = 6'd6;
        else if (len == 16'd3 && w == kw_pack("for"))       r = 6'd7;
        else if (len == 16'd8 && w == kw_pack("function"))  r = 6'd8;
        else if (len == 16'd2 && w == kw_pack("if"))        r = 6'd9;
        else if (len == 16'd4 && w == kw_pack("load"))      r = 6'd10;
        else if (len == 16'd4 && w == kw_pack("loop"))      r = 6'd11;
        else if (len == 16'd4 && w == kw_pack("next"))      r = 6'd12;
        else if (len == 16'd3 && w == kw_pack("not"))       r = 6'd13;
        else if (len == 16'd2 && w == kw_pack("or"))        r = 6'd14;
        else if (len == 16'd6 && w == kw_pack("select"))    r = 6'd15;
        else if (len == 16'd4 && w == kw_pack("step"))      r = 6'd16;
        else if (len == 16'd9 && w == kw_pack("structure")) r = 6'd17;
        else if (len == 16'd3 && w == kw_pack("sub"))       r = 6'd18;
        else if (len == 16'd4 && w == kw_pack("then"))      r = 6'd19;
        else if (len == 16'd2 && w == kw_pack("to"))        r = 6'd20;
        else if (len == 16'd5 && w == kw_pack("until"))     r = 6'd21;
        else if (len == 16'd3 && w == kw_pack("var"))       r = 6'd22;
        else if (len == 16'd5 && w == kw_pack("while"))     r = 6'd23;
        return r;
    endfunction

endpackage

@@ hw/rtl/bst_front.sv @@
// ----------------------------------------------------------------------------
// bst_front
// Lexer state machine: classifies each byte and builds up to two tokens.
// ----------------------------------------------------------------------------
module bst_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic              action,
    input  logic [7:0]        char_code,
    output bst_pkg::entry_t   entry
);

    bst_pkg::mode_t mode_reg, mode_next;
    logic [31:0] offset_reg, offset_next;
    logic [31:0] start_reg, start_next;
    logic [15:0] length_reg, length_next;
    bst_pkg::window_t window_reg, window_next;
    logic dot_reg, dot_next;
    logic [7:0] held_reg, held_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= bst_pkg::M_IDLE;
            offset_reg <= '0;
            start_reg  <= '0;
            length_reg <= '0;
            window_reg <= '0;
            dot_reg    <= 1'b0;
            held_reg   <= '0;
        end else if (in_valid) begin
            mode_reg   <= mode_next;
            offset_reg <= offset_next;
            start_reg  <= start_next;
            length_reg <= length_next;
            window_reg <= window_next;
            dot_reg    <= dot_next;
            held_reg   <= held_next;
        end
    end

    logic [15:0] grown;
    assign grown = (length_reg == bst_pkg::LenMax) ? length_reg : length_reg + 16'd1;

    always_comb begin
        bst_pkg::tok_t fin;
        logic          fin_v;
        logic          do_start;
        logic [5:0]    kw;
        logic [5:0]    sym;
        logic [7:0]    b;
        b           = char_code;
        mode_next   = mode_reg;
        offset_next = offset_reg;
        start_next  = start_reg;
        length_next = length_reg;
        window_next = window_reg;
        dot_next    = dot_reg;
        held_next   = held_reg;
        entry       = '0;
        do_start    = 1'b0;
        kw          = bst_pkg::keyword_code(window_reg, length_reg);
        sym         = bst_pkg::single_symbol(b);

        // Token left pending by the current mode.
        fin   = '0;
        fin_v = 1'b1;
        fin.pos = start_reg;
        unique case (mode_reg)
            bst_pkg::M_IDENT: begin
                fin.ttype = (kw != 6'd0) ? kw : bst_pkg::T_IDENT;
                fin.len   = (kw != 6'd0) ? 16'd0 : length_reg;
            end
            bst_pkg::M_NUMBER: begin
                fin.ttype = dot_reg ? bst_pkg::T_FLOAT : bst_pkg::T_INT;
                fin.len   = length_reg;
            end
            bst_pkg::M_STRING: begin
                fin.ttype = bst_pkg::T_UNTERM;
                fin.len   = length_reg;
            end
            bst_pkg::M_ASSIGN: fin.ttype = bst_pkg::T_ASSIGN;
            bst_pkg::M_LESS:   fin.ttype = bst_pkg::T_LESS;
            bst_pkg::M_SIGN:
                fin.ttype = (held_reg == 8'h2D) ? bst_pkg::T_MINUS : bst_pkg::T_PLUS;
            default: fin_v = 1'b0;
        endcase

        if (action) begin
            // End of input: flush, then eof.
            if (fin_v) begin
                entry.t0 = fin;
                entry.t1 = '{ttype: bst_pkg::T_EOF, pos: offset_reg, len: 16'd0};
                entry.cnt = 2'd2;
            end else begin
                entry.t0 = '{ttype: bst_pkg::T_EOF, pos: offset_reg, len: 16'd0};
                entry.cnt = 2'd1;
            end
            mode_next   = bst_pkg::M_IDLE;
            offset_next = '0;
        end else begin
            offset_next = offset_reg + 32'd1;
            unique case (mode_reg)
                bst_pkg::M_COMMENT: if (b == 8'h0A) mode_next = bst_pkg::M_IDLE;
                bst_pkg::M_STRING: begin
                    if (b == 8'h22) begin
                        entry.t0 = '{ttype: bst_pkg::T_STRING, pos: start_reg, len: length_reg};
                        entry.cnt = 2'd1;
                        mode_next = bst_pkg::M_IDLE;
                    end else begin
                        length_next = grown;
                    end
                end
                bst_pkg::M_IDENT: begin
                    if (bst_pkg::is_delim(b)) begin
                        do_start = 1'b1;
                    end else begin
                        for (int i = 0; i < bst_pkg::KwLen; i++) begin
                            if (length_reg == 16'(i)) window_next[i*8 +: 8] = b;
                        end
                        length_next = grown;
                    end
                end
                bst_pkg::M_NUMBER: begin
                    if (bst_pkg::is_digit(b) || b == 8'h2B || b == 8'h2D || b == 8'h65
                        || b == 8'h45 || b == 8'h2E) begin
                        if (b == 8'h2E) dot_next = 1'b1;
                        length_next = grown;
                    end else begin
                        do_start = 1'b1;
                    end
                end
                bst_pkg::M_ASSIGN: begin
                    if (b == 8'h3D) begin
                        entry.t0 = '{ttype: bst_pkg::T_EQUAL, pos: start_reg, len: 16'd0};
                        entry.cnt = 2'd1;
                        mode_next = bst_pkg::M_IDLE;
                    end else begin
                        do_start = 1'b1;
                    end
                end
                bst_pkg::M_LESS: begin
                    if (b == 8'h3E) begin
                        entry.t0 = '{ttype: bst_pkg::T_NOTEQ, pos: start_reg, len: 16'd0};
                        entry.cnt = 2'd1;
                        mode_next = bst_pkg::M_IDLE;
                    end else begin
                        do_start = 1'b1;
                    end
                end
                bst_pkg::M_SIGN: begin
                    if (bst_pkg::is_digit(b)) begin
                        length_next = 16'd2;
                        dot_next    = 1'b0;
                        mode_next   = bst_pkg::M_NUMBER;
                    end else begin
                        do_start = 1'b1;
                    end
                end
                default: do_start = 1'b1;
            endcase

            if (do_start) begin
                if (fin_v) begin
                    entry.t0  = fin;
                    entry.cnt = 2'd1;
                end
                mode_next = bst_pkg::M_IDLE;
                if (!bst_pkg::is_space(b)) begin
                    start_next = offset_reg;
                    if (b == 8'h23) begin
                        mode_next = bst_pkg::M_COMMENT;
                    end else if ((b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A)
                                 || b == 8'h5F) begin
                        window_next        = '0;
                        window_next[7:0]   = b;
                        length_next        = 16'd1;
                        mode_next          = bst_pkg::M_IDENT;
                    end else if (b == 8'h22) begin
                        length_next = 16'd0;
                        mode_next   = bst_pkg::M_STRING;
                    end else if (bst_pkg::is_digit(b)) begin
                        length_next = 16'd1;
                        dot_next    = 1'b0;
                        mode_next   = bst_pkg::M_NUMBER;
                    end else if (b == 8'h2B || b == 8'h2D) begin
                        held_next = b;
                        mode_next = bst_pkg::M_SIGN;
                    end else if (b == 8'h3D) begin
                        mode_next = bst_pkg::M_ASSIGN;
                    end else if (b == 8'h3C) begin
                        mode_next = bst_pkg::M_LESS;
                    end else begin
                        if (fin_v) begin
                            entry.t1  = '{ttype: (sym != 6'd0) ? sym : bst_pkg::T_BAD,
                                          pos: offset_reg,
                                          len: (sym != 6'd0) ? 16'd0 : 16'd1};
                            entry.cnt = 2'd2;
                        end else begin
                            entry.t0  = '{ttype: (sym != 6'd0) ? sym : bst_pkg::T_BAD,
                                          pos: offset_reg,
                                          len: (sym != 6'd0) ? 16'd0 : 16'd1};
                            entry.cnt = 2'd1;
                        end
                    end
                end
            end
        end
    end

endmodule

@@ hw/rtl/bst_queue.sv @@
// ----------------------------------------------------------------------------
// bst_queue
// Small FIFO of token groups between the lexer and the output stage.
// ----------------------------------------------------------------------------
module bst_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_en,
    input  bst_pkg::entry_t wr_data,
    output logic            full,
    output logic            empty,
    input  logic            rd_en,
    output bst_pkg::entry_t rd_data
);

    bst_pkg::entry_t mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;

    assign full    = cnt_reg == 3'd4;
    assign empty   = cnt_reg == 3'd0;
    assign rd_data = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (wr_en) mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr_en) wp_reg <= wp_reg + 2'd1;
            if (rd_en) rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + {2'b0, wr_en} - {2'b0, rd_en};
        end
    end

endmodule

@@ hw/rtl/bst_back.sv @@
// ----------------------------------------------------------------------------
// bst_back
// Output stage: sends the one or two tokens of each group in order.
// ----------------------------------------------------------------------------
module bst_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_empty,
    input  bst_pkg::entry_t q_data,
    output logic            q_pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [5:0]      m_token_type,
    output logic [31:0]     m_token_position,
    output logic [15:0]     m_text_length,
    output logic            m_is_last
);

    logic second_reg;
    bst_pkg::tok_t cur;

    assign cur              = second_reg ? q_data.t1 : q_data.t0;
    assign m_valid          = !q_empty;
    assign m_token_type     = cur.ttype;
    assign m_token_position = cur.pos;
    assign m_text_length    = cur.len;
    assign m_is_last        = second_reg || q_data.cnt == 2'd1;
    assign q_pop            = m_valid && m_ready && m_is_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            second_reg <= 1'b0;
        end else if (m_valid && m_ready) begin
            second_reg <= !m_is_last;
        end
    end

endmodule

@@ hw/rtl/basic_source_tokenizer_core.sv @@
// ----------------------------------------------------------------------------
// basic_source_tokenizer_core
// Byte-serial tokenizer: one request per cycle in, tokens out.
// ----------------------------------------------------------------------------
// Path: the request that ends a token writes it into the token queue; m_ shows the queue head.
// Throughput: one request per cycle while the 4-deep token queue has room;
// a request that gives two tokens holds its group at the queue head until both are sent.
// Reset: aresetn (synchronous, active low) returns the lexer to idle,
// clears the byte offset and empties the queue.
// ----------------------------------------------------------------------------
module basic_source_tokenizer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [7:0]  s_char_code,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_token_type,
    output logic [31:0] m_token_position,
    output logic [15:0] m_text_length,
    output logic        m_is_last
);

    bst_pkg::entry_t entry, q_data;
    logic take, q_full, q_empty, q_pop;

    // Accept whenever the queue has room; requests with no tokens skip it.
    assign s_ready = !q_full;
    assign take    = s_valid && s_ready;

    bst_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (take),
        .action    (s_action),
        .char_code (s_char_code),
        .entry     (entry)
    );

    bst_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (take && entry.cnt != 2'd0),
        .wr_data (entry),
        .full    (q_full),
        .empty   (q_empty),
        .rd_en   (q_pop),
        .rd_data (q_data)
    );

    bst_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_empty          (q_empty),
        .q_data           (q_data),
        .q_pop            (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_token_type     (m_token_type),
        .m_token_position (m_token_position),
        .m_text_length    (m_text_length),
        .m_is_last        (m_is_last)
    );

endmodule

@@ hw/rtl/bst_checker.sv @@
// ----------------------------------------------------------------------------
// bst_checker
// Port-level checks on the tokenizer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bst_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [5:0]  m_token_type,
    input logic [15:0] m_text_length,
    input logic        m_is_last
);

    logic is_eof;
    logic is_fixed;

    assign is_eof   = m_token_type == bst_pkg::T_EOF;
    // Keywords and symbols carry no text.
    assign is_fixed = !is_eof && m_token_type < bst_pkg::T_IDENT;

    `ASSERT_IMPLIES(a_type_range, aclk, aresetn, m_valid, m_token_type <= bst_pkg::T_BAD, "bad token type")
    `ASSERT_IMPLIES(a_eof_last, aclk, aresetn, m_valid && is_eof, m_is_last, "eof not last")
    `ASSERT_IMPLIES(a_kw_len, aclk, aresetn, m_valid && is_fixed, m_text_length == '0, "keyword with length")
    `ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid, "valid dropped")
    `ASSERT_NEXT(a_in_hold, aclk, aresetn, s_valid && !s_ready, s_valid, "request dropped")

endmodule

bind basic_source_tokenizer_core bst_checker u_bst_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_token_type  (m_token_type),
    .m_text_length (m_text_length),
    .m_is_last     (m_is_last)
);

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// Source tokenizer testbench
// Feeds byte and end requests through the valid/ready input channel, predicts
// the token stream with a behavioral lexer and compares each token field by
// field. Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IdleLimit = 2000;

    typedef struct packed {
        logic       act;
        logic [7:0] ch;
        logic       hold;   // pause until every expected token has come
    } req_t;

    typedef struct packed {
        logic [5:0]  ttype;
        logic [31:0] pos;
        logic [15:0] len;
        logic        last;
    } token_exp_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_action = 1'b0;
    logic [7:0]  s_char_code = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [5:0]  m_token_type;
    logic [31:0] m_token_position;
    logic [15:0] m_text_length;
    logic        m_is_last;

    always #2 aclk = ~aclk;

    basic_source_tokenizer_core dut (.*);

    // Lexer state mirrored by the predictor.
    bst_pkg::mode_t lx_mode = bst_pkg::M_IDLE;
    logic [31:0] lx_offset = '0;
    logic [31:0] lx_start = '0;
    logic [15:0] lx_len = '0;
    logic [7:0]  lx_word [bst_pkg::KwLen];
    logic        lx_dot = 1'b0;
    logic [7:0]  lx_sign = '0;

    req_t        pending_reqs [$];
    token_exp_t  expected_tokens [$];
    token_exp_t  step_toks [$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    bit          stim_done = 1'b0;
    bit          timed_out = 1'b0;

    function automatic logic [5:0] sym_code(input logic [7:0] b);
        case (b)
            "(": return 6'd24;
            ")": return 6'd25;
            "[": return 6'd26;
            "]": return 6'd27;
            "=": return bst_pkg::T_ASSIGN;
            "+": return bst_pkg::T_PLUS;
            "-": return bst_pkg::T_MINUS;
            "*": return 6'd32;
            "/": return 6'd33;
            "<": return bst_pkg::T_LESS;
            ">": return 6'd35;
            ",": return 6'd37;
            ".": return 6'd38;
            default: return 6'd0;
        endcase
    endfunction

    function automatic bit blank(input logic [7:0] b);
        return b == " " || b == 8'h09 || b == 8'h0A;
    endfunction

    function automatic bit numeral(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit ends_word(input logic [7:0] b);
        return blank(b) || b == "#" || b == 8'h22 || sym_code(b) != 0;
    endfunction

    function automatic logic [5:0] lookup_keyword();
        string words [23];
        string w;
        bit    hit;
        words = '{"and", "as", "case", "do", "else", "end", "for", "function", "if",
                  "load", "loop", "next", "not", "or", "select", "step", "structure",
                  "sub", "then", "to", "until", "var", "while"};
        for (int k = 0; k < 23; k++) begin
            w = words[k];
            if (w.len() != lx_len || w.len() > bst_pkg::KwLen) continue;
            hit = 1'b1;
            for (int i = 0; i < w.len(); i++)
                if (lx_word[i] != w[i]) hit = 1'b0;
            if (hit) return 6'(k + 1);
        end
        return 6'd0;
    endfunction

    function automatic void push_token(input logic [5:0] t, input logic [31:0] p,
                                       input logic [15:0] l);
        token_exp_t e;
        e = '{ttype: t, pos: p, len: l, last: 1'b0};
        if (step_toks.size() < 2) step_toks.insert(step_toks.size(), e);
    endfunction

    // Flush whatever token is in progress.
    function automatic void close_token();
        logic [5:0] kw;
        case (lx_mode)
            bst_pkg::M_IDENT: begin
                kw = lookup_keyword();
                if (kw != 0) push_token(kw, lx_start, 16'd0);
                else push_token(bst_pkg::T_IDENT, lx_start, lx_len);
            end
            bst_pkg::M_NUMBER:
                push_token(lx_dot ? bst_pkg::T_FLOAT : bst_pkg::T_INT, lx_start, lx_len);
            bst_pkg::M_STRING: push_token(bst_pkg::T_UNTERM, lx_start, lx_len);
            bst_pkg::M_ASSIGN: push_token(bst_pkg::T_ASSIGN, lx_start, 16'd0);
            bst_pkg::M_LESS:   push_token(bst_pkg::T_LESS, lx_start, 16'd0);
            bst_pkg::M_SIGN:
                push_token(lx_sign == "-" ? bst_pkg::T_MINUS : bst_pkg::T_PLUS,
                           lx_start, 16'd0);
            default: ;
        endcase
        lx_mode = bst_pkg::M_IDLE;
    endfunction

    // Handle a byte as if the lexer were idle.
    function automatic void open_token(input logic [7:0] b, input logic [31:0] p);
        logic [5:0] s;
        lx_mode = bst_pkg::M_IDLE;
        if (blank(b)) return;
        lx_start = p;
        if (b == "#") lx_mode = bst_pkg::M_COMMENT;
        else if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_") begin
            foreach (lx_word[i]) lx_word[i] = 8'h00;
            lx_word[0] = b;
            lx_len = 16'd1;
            lx_mode = bst_pkg::M_IDENT;
        end else if (b == 8'h22) begin
            lx_len = 16'd0;
            lx_mode = bst_pkg::M_STRING;
        end else if (numeral(b)) begin
            lx_len = 16'd1;
            lx_dot = 1'b0;
            lx_mode = bst_pkg::M_NUMBER;
        end else if (b == "+" || b == "-") begin
            lx_sign = b;
            lx_mode = bst_pkg::M_SIGN;
        end else if (b == "=") lx_mode = bst_pkg::M_ASSIGN;
        else if (b == "<") lx_mode = bst_pkg::M_LESS;
        else begin
            s = sym_code(b);
            if (s != 0) push_token(s, p, 16'd0);
            else push_token(bst_pkg::T_BAD, p, 16'd1);
        end
    endfunction

    function automatic void lengthen();
        if (lx_len != bst_pkg::LenMax) lx_len++;
    endfunction

    // Advance the lexer by one request and queue the tokens it yields.
    function automatic void predict_tokens(input logic act, input logic [7:0] b);
        step_toks.delete();
        if (act) begin
            close_token();
            push_token(bst_pkg::T_EOF, lx_offset, 16'd0);
            lx_offset = '0;
        end else begin
            case (lx_mode)
                bst_pkg::M_COMMENT: if (b == 8'h0A) lx_mode = bst_pkg::M_IDLE;
                bst_pkg::M_STRING: begin
                    if (b == 8'h22) begin
                        push_token(bst_pkg::T_STRING, lx_start, lx_len);
                        lx_mode = bst_pkg::M_IDLE;
                    end else lengthen();
                end
                bst_pkg::M_IDENT: begin
                    if (ends_word(b)) begin
                        close_token();
                        open_token(b, lx_offset);
                    end else begin
                        if (lx_len < bst_pkg::KwLen) lx_word[lx_len] = b;
                        lengthen();
                    end
                end
                bst_pkg::M_NUMBER: begin
                    if (numeral(b) || b == "+" || b == "-" || b == "e" || b == "E"
                        || b == ".") begin
                        if (b == ".") lx_dot = 1'b1;
                        lengthen();
                    end else begin
                        close_token();
                        open_token(b, lx_offset);
                    end
                end
                bst_pkg::M_ASSIGN: begin
                    if (b == "=") begin
                        push_token(bst_pkg::T_EQUAL, lx_start, 16'd0);
                        lx_mode = bst_pkg::M_IDLE;
                    end else begin
                        close_token();
                        open_token(b, lx_offset);
                    end
                end
                bst_pkg::M_LESS: begin
                    if (b == ">") begin
                        push_token(bst_pkg::T_NOTEQ, lx_start, 16'd0);
                        lx_mode = bst_pkg::M_IDLE;
                    end else begin
                        close_token();
                        open_token(b, lx_offset);
                    end
                end
                bst_pkg::M_SIGN: begin
                    if (numeral(b)) begin
                        lx_len = 16'd2;
                        lx_dot = 1'b0;
                        lx_mode = bst_pkg::M_NUMBER;
                    end else begin
                        close_token();
                        open_token(b, lx_offset);
                    end
                end
                default: open_token(b, lx_offset);
            endcase
            lx_offset++;
        end
        if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1'b1;
        foreach (step_toks[i]) expected_tokens.insert(expected_tokens.size(), step_toks[i]);
    endfunction

    // Stimulus helpers: append source text or an end mark.
    task automatic add_text(input string s);
        req_t r;
        for (int i = 0; i < s.len(); i++) begin
            r = '{act: 1'b0, ch: s[i], hold: 1'b0};
            pending_reqs.insert(pending_reqs.size(), r);
        end
    endtask

    task automatic add_end(input bit hold);
        req_t r;
        r = '{act: 1'b1, ch: 8'($urandom), hold: hold};
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    // Random fragment of source text: mostly well-formed lexemes, sometimes a raw byte.
    function automatic string random_lexeme();
        string frags [] = '{"and", "as", "case", "do", "else", "end", "for", "function",
            "if", "load", "loop", "next", "not", "or", "select", "step", "structure",
            "sub", "then", "to", "until", "var", "while", "==", "<>", "=", "<", ">",
            "(", ")", "[", "]", "+", "-", "*", "/", ",", ".", "\n", "# note\n"};
        string s;
        int    n;
        case ($urandom_range(0, 7))
            0, 1: s = frags[$urandom_range(0, frags.size()-1)];
            2: begin
                s = "";
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++) s = {s, string'(8'("a" + $urandom_range(0, 25)))};
                s = {s, string'(8'("_"))};
            end
            3: s = $sformatf("%0d", $urandom_range(0, 99999));
            4: s = $sformatf("%s%0d.%0de%s%0d", $urandom_range(0, 1) ? "-" : "+",
                   $urandom_range(0, 99), $urandom_range(0, 99),
                   $urandom_range(0, 1) ? "-" : "+", $urandom_range(0, 9));
            5: s = $sformatf("\"str %0d\"", $urandom_range(0, 999));
            6: s = string'(8'($urandom));
            default: s = " ";
        endcase
        return s;
    endfunction

    initial begin
        foreach (lx_word[i]) lx_word[i] = 8'h00;
        // Directed: keywords, paired symbols, signs, numbers, strings,
        // comments, bad byte, unterminated string, comment at end.
        add_text("if x<>1 == +3.5e-2 -y \"\"");
        add_end(1'b0);
        add_text("structures structure# c\n=<@\"ab");
        add_end(1'b1);
        add_text("x# open");
        add_end(1'b0);
        add_text({string'(8'hFF), string'(8'h00), "[]"});
        add_end(1'b0);
        add_end(1'b0);
        // Random: mostly lexemes, some raw noise, an end every so often.
        while (pending_reqs.size() < 1650) begin
            if ($urandom_range(0, 40) == 0) add_end($urandom_range(0, 9) == 0);
            else add_text(random_lexeme());
        end
        add_end(1'b0);
    end

    // Driver: hold each request until accepted, burst then gap.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_ready) begin
            // hold
        end else begin
            if (s_valid) predict_tokens(s_action, s_char_code);
            if (pending_reqs.size() == 0) begin
                s_valid <= 1'b0;
                stim_done <= 1'b1;
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_valid <= 1'b0;
            end else if (pending_reqs[0].hold && (expected_tokens.size() != 0 || s_valid)) begin
                s_valid <= 1'b0;
            end else begin
                s_valid <= 1'b1;
                s_action <= pending_reqs[0].act;
                s_char_code <= pending_reqs[0].ch;
                pending_reqs.delete(0);
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
                end else burst_left <= burst_left - 1;
            end
        end
    end

    // Monitor: compare every accepted token with the oldest prediction.
    always @(posedge aclk) begin
        token_exp_t e;
        if (aresetn) begin
            m_ready <= ($urandom_range(0, 255) < 128) ? 1'b1 : ($urandom_range(0, 3) != 0);
            if (m_valid && m_ready) begin
                idle_cycles <= 0;
                if (expected_tokens.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected token type %0d pos %0d len %0d",
                                 m_token_type, m_token_position, m_text_length);
                end else begin
                    e = expected_tokens[0];
                    expected_tokens.delete(0);
                    if (e.ttype !== m_token_type || e.pos !== m_token_position
                        || e.len !== m_text_length || e.last !== m_is_last) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("token mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                     e.ttype, e.pos, e.len, e.last, m_token_type,
                                     m_token_position, m_text_length, m_is_last);
                    end
                end
            end else if (s_valid && s_ready) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        fork
            begin
                wait (stim_done && !s_valid && expected_tokens.size() == 0);
                repeat (20) @(posedge aclk);
            end
            begin
                wait (idle_cycles >= IdleLimit);
                timed_out = 1'b1;
            end
        join_any
        if (!timed_out && mismatches == 0 && expected_tokens.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
